// ===== design/button_press_hold_release_detector_core_assert.svh =====
// Assertion macros shared by the detector checker.
`ifndef BUTTON_PRESS_HOLD_RELEASE_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_PRESS_HOLD_RELEASE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define BPHRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define BPHRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bphrd_pkg.sv =====
// Shared types and constants for the button press, hold and release detector.
`default_nettype none

package bphrd_pkg;

  localparam int CFG_W = 16;
  localparam int ADDR_W = 2;
  localparam int KIND_W = 2;
  localparam int KEY_W = 3;
  localparam int TIME_W = 32;
  localparam int LEVEL_W = 8;

  localparam logic [ADDR_W-1:0] REG_PRESS_MS = 2'd0;
  localparam logic [ADDR_W-1:0] REG_RELEASE_MS = 2'd1;
  localparam logic [ADDR_W-1:0] REG_HOLD_MS = 2'd2;

  localparam logic [CFG_W-1:0] PRESS_MS_RESET = 16'd50;
  localparam logic [CFG_W-1:0] RELEASE_MS_RESET = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_MS_RESET = 16'd500;

  localparam logic [KIND_W-1:0] KIND_PRESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOLD = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
  } lane_event_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] press_ms;
    logic [CFG_W-1:0] release_ms;
    logic [CFG_W-1:0] hold_ms;
  } timing_cfg_t;

endpackage

`default_nettype wire

// ===== design/bphrd_key_lane.sv =====
// Debounce state machine for one key, producing press, hold and release events.
`default_nettype none

module bphrd_key_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic                          down,
  input  wire logic [bphrd_pkg::TIME_W-1:0]  now,
  input  wire bphrd_pkg::timing_cfg_t        cfg,
  output bphrd_pkg::lane_event_t             ev
);

  typedef enum logic [2:0] {
    IDLE        = 3'd0,
    PENDING     = 3'd1,
    PRESSED     = 3'd2,
    HELD        = 3'd3,
    REL_PRESSED = 3'd4,
    REL_HELD    = 3'd5
  } mode_t;

  mode_t                          mode;
  mode_t                          mode_next;
  logic [bphrd_pkg::TIME_W-1:0]   press_start;
  logic [bphrd_pkg::TIME_W-1:0]   press_start_next;
  logic [bphrd_pkg::TIME_W-1:0]   elapsed;
  logic [bphrd_pkg::CFG_W-1:0]    limit;
  logic                           reached;

  assign elapsed = now - press_start;

  always_comb begin
    unique case (mode)
      PENDING:               limit = cfg.press_ms;
      PRESSED:               limit = cfg.hold_ms;
      REL_PRESSED, REL_HELD: limit = cfg.release_ms;
      default:               limit = cfg.release_ms;
    endcase
  end

  assign reached = elapsed >= {{(bphrd_pkg::TIME_W - bphrd_pkg::CFG_W){1'b0}}, limit};

  always_comb begin
    mode_next = mode;
    press_start_next = press_start;
    ev.valid = 1'b0;
    ev.kind = bphrd_pkg::KIND_PRESS;
    unique case (mode)
      REL_PRESSED, REL_HELD: begin
        if (down) begin
          mode_next = (mode == REL_PRESSED) ? PRESSED : HELD;
        end else if (reached) begin
          mode_next = IDLE;
          ev.valid = 1'b1;
          ev.kind = bphrd_pkg::KIND_RELEASE;
        end
      end
      PENDING: begin
        if (!down) begin
          mode_next = IDLE;
        end else if (reached) begin
          mode_next = PRESSED;
          ev.valid = 1'b1;
          ev.kind = bphrd_pkg::KIND_PRESS;
        end
      end
      PRESSED: begin
        if (!down) begin
          press_start_next = now;
          mode_next = REL_PRESSED;
        end else if (reached) begin
          mode_next = HELD;
          ev.valid = 1'b1;
          ev.kind = bphrd_pkg::KIND_HOLD;
        end
      end
      HELD: begin
        if (!down) begin
          press_start_next = now;
          mode_next = REL_HELD;
        end
      end
      default: begin
        if (down) begin
          press_start_next = now;
          mode_next = PENDING;
        end else begin
          mode_next = IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= IDLE;
      press_start <= '0;
    end else if (step) begin
      mode <= mode_next;
      press_start <= press_start_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/bphrd_event_store.sv =====
// Small event store: writes events of one sample in key order, reads the oldest.
`default_nettype none

module bphrd_event_store #(
  parameter int KEYS = 1,
  parameter int EVENT_DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   sample_step,
  input  wire logic                   read_step,
  input  wire bphrd_pkg::lane_event_t lane_ev [KEYS],
  output logic                        rd_hit,
  output bphrd_pkg::event_t           rd_entry
);

  localparam int CNT_W = $clog2(EVENT_DEPTH + 1);
  localparam int IDX_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

  bphrd_pkg::event_t store      [EVENT_DEPTH];
  bphrd_pkg::event_t store_next [EVENT_DEPTH];
  logic [CNT_W-1:0]  write_count;
  logic [CNT_W-1:0]  write_count_next;
  logic [CNT_W-1:0]  read_count;
  logic [CNT_W-1:0]  read_count_next;
  logic [CNT_W-1:0]  read_inc;
  logic [CNT_W-1:0]  pos;

  assign rd_hit = read_count < write_count;
  assign rd_entry = store[read_count[IDX_W-1:0]];
  assign read_inc = read_count + CNT_W'(1);

  always_comb begin
    store_next = store;
    pos = write_count;
    for (int i = 0; i < KEYS; i++) begin
      if (lane_ev[i].valid && (pos < CNT_W'(EVENT_DEPTH))) begin
        store_next[pos[IDX_W-1:0]].kind = lane_ev[i].kind;
        store_next[pos[IDX_W-1:0]].key = bphrd_pkg::KEY_W'(i);
        pos = pos + CNT_W'(1);
      end
    end
  end

  always_comb begin
    write_count_next = write_count;
    read_count_next = read_count;
    if (sample_step) begin
      write_count_next = pos;
    end else if (read_step && rd_hit) begin
      if (read_inc == write_count) begin
        write_count_next = '0;
        read_count_next = '0;
      end else begin
        read_count_next = read_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      read_count <= '0;
    end else begin
      write_count <= write_count_next;
      read_count <= read_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_step) begin
      store <= store_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/button_press_hold_release_detector_core.sv =====
// An accepted item passes through the input register and then the result register before its result shows.
// Throughput: one item per cycle while results are taken; the input register holds one new item while a result waits.
// Per-sample work is one subtract and compare per key plus a key-ordered store update; a read returns the oldest event.
// Reset clears key states, press start times and store counts, and loads the timing registers with their reset values.
// Store entries are not cleared; only written entries are ever read.
`default_nettype none

module button_press_hold_release_detector_core #(
  parameter int KEYS = 1,
  parameter int EVENT_DEPTH = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [bphrd_pkg::ADDR_W-1:0]      cfg_addr,
  input  wire logic [bphrd_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              op,
  input  wire logic [bphrd_pkg::LEVEL_W-1:0]     key_levels,
  input  wire logic [bphrd_pkg::TIME_W-1:0]      time_now,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   event_valid,
  output logic [bphrd_pkg::KIND_W-1:0]           event_kind,
  output logic [bphrd_pkg::KEY_W-1:0]            event_key,
  output logic                                   notify
);

  bphrd_pkg::timing_cfg_t         cfg;
  logic                           in_full;
  logic                           op_q;
  logic [KEYS-1:0]                levels_q;
  logic [bphrd_pkg::TIME_W-1:0]   time_q;
  logic                           advance;
  logic                           sample_step;
  logic                           read_step;
  bphrd_pkg::lane_event_t         lane_ev [KEYS];
  logic [KEYS-1:0]                lane_hit;
  logic                           rd_hit;
  bphrd_pkg::event_t              rd_entry;

  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign sample_step = advance && (op_q == bphrd_pkg::OP_SAMPLE);
  assign read_step = advance && (op_q == bphrd_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_ms <= bphrd_pkg::PRESS_MS_RESET;
      cfg.release_ms <= bphrd_pkg::RELEASE_MS_RESET;
      cfg.hold_ms <= bphrd_pkg::HOLD_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bphrd_pkg::REG_PRESS_MS:   cfg.press_ms <= cfg_wdata;
        bphrd_pkg::REG_RELEASE_MS: cfg.release_ms <= cfg_wdata;
        bphrd_pkg::REG_HOLD_MS:    cfg.hold_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= op;
      levels_q <= key_levels[KEYS-1:0];
      time_q <= time_now;
    end
  end

  for (genvar g = 0; g < KEYS; g++) begin : g_lane
    bphrd_key_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .step (sample_step),
      .down (levels_q[g]),
      .now  (time_q),
      .cfg  (cfg),
      .ev   (lane_ev[g])
    );
    assign lane_hit[g] = lane_ev[g].valid;
  end

  bphrd_event_store #(
    .KEYS        (KEYS),
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .sample_step (sample_step),
    .read_step   (read_step),
    .lane_ev     (lane_ev),
    .rd_hit      (rd_hit),
    .rd_entry    (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (op_q == bphrd_pkg::OP_READ) begin
        event_valid <= rd_hit;
        event_kind <= rd_hit ? rd_entry.kind : bphrd_pkg::KIND_PRESS;
        event_key <= rd_hit ? rd_entry.key : '0;
        notify <= 1'b0;
      end else begin
        event_valid <= 1'b0;
        event_kind <= bphrd_pkg::KIND_PRESS;
        event_key <= '0;
        notify <= |lane_hit;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bphrd_checker.sv =====
// Port-level checker for the detector core and its bind statement.
`default_nettype none

`include "button_press_hold_release_detector_core_assert.svh"

module bphrd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          event_valid,
  input wire logic [bphrd_pkg::KIND_W-1:0]  event_kind,
  input wire logic [bphrd_pkg::KEY_W-1:0]   event_key,
  input wire logic                          notify
);

  `BPHRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_valid) && $stable(event_kind) && $stable(event_key) && $stable(notify), "Stalled result changed before transfer.")
  `BPHRD_ASSERT_NOW(a_read_no_notify, out_valid && event_valid, !notify, "A read result carries notify.")
  `BPHRD_ASSERT_NOW(a_empty_zero, out_valid && !event_valid, (event_kind == bphrd_pkg::KIND_PRESS) && (event_key == '0), "A result without an event has nonzero event fields.")
  `BPHRD_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "Input is stalled while the result register is empty.")

endmodule

bind button_press_hold_release_detector_core bphrd_checker u_bphrd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .event_valid (event_valid),
  .event_kind  (event_kind),
  .event_key   (event_key),
  .notify      (notify)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the debounced key press, hold and release detector.
module tb;

  localparam int NUM_KEYS = 1;
  localparam int STORE_DEPTH = 2;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    KEY_IDLE,
    KEY_PENDING,
    KEY_PRESSED,
    KEY_HELD,
    KEY_REL_PRESSED,
    KEY_REL_HELD
  } key_mode_t;

  typedef struct packed {
    logic                         ev_valid;
    logic [bphrd_pkg::KIND_W-1:0] kind;
    logic [bphrd_pkg::KEY_W-1:0]  key;
    logic                         notify;
  } result_t;

  class detector_scoreboard;
    key_mode_t                    mode [NUM_KEYS];
    logic [bphrd_pkg::TIME_W-1:0] since_ms [NUM_KEYS];
    bphrd_pkg::event_t            store [STORE_DEPTH];
    int unsigned                  wr_cnt;
    int unsigned                  rd_cnt;
    logic [bphrd_pkg::CFG_W-1:0]  press_ms;
    logic [bphrd_pkg::CFG_W-1:0]  release_ms;
    logic [bphrd_pkg::CFG_W-1:0]  hold_ms;
    result_t                      expected_results [$];
    int unsigned                  mismatches;
    int unsigned                  checked;
    int unsigned                  events_read;
    int unsigned                  notify_ticks;

    function new();
      for (int k = 0; k < NUM_KEYS; k++) begin
        mode[k] = KEY_IDLE;
        since_ms[k] = '0;
      end
      wr_cnt = 0;
      rd_cnt = 0;
      press_ms = bphrd_pkg::PRESS_MS_RESET;
      release_ms = bphrd_pkg::RELEASE_MS_RESET;
      hold_ms = bphrd_pkg::HOLD_MS_RESET;
      mismatches = 0;
      checked = 0;
      events_read = 0;
      notify_ticks = 0;
    endfunction

    function void set_reg(logic [bphrd_pkg::ADDR_W-1:0] idx,
                          logic [bphrd_pkg::CFG_W-1:0] val);
      case (idx)
        bphrd_pkg::REG_PRESS_MS: press_ms = val;
        bphrd_pkg::REG_RELEASE_MS: release_ms = val;
        bphrd_pkg::REG_HOLD_MS: hold_ms = val;
        default: ;
      endcase
    endfunction

    function bit reached(logic [bphrd_pkg::TIME_W-1:0] now,
                         logic [bphrd_pkg::TIME_W-1:0] start,
                         logic [bphrd_pkg::CFG_W-1:0] limit);
      logic [bphrd_pkg::TIME_W-1:0] span;
      span = now - start;
      return span >= {16'd0, limit};
    endfunction

    function void push_event(logic [bphrd_pkg::KIND_W-1:0] kind,
                             logic [bphrd_pkg::KEY_W-1:0] key);
      if (wr_cnt < STORE_DEPTH) begin
        store[wr_cnt].kind = kind;
        store[wr_cnt].key = key;
        wr_cnt++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_item(logic op_i, logic [bphrd_pkg::LEVEL_W-1:0] levels,
                            logic [bphrd_pkg::TIME_W-1:0] now);
      result_t r;
      logic down;
      logic any;
      r = '0;
      if (op_i == bphrd_pkg::OP_READ) begin
        if (rd_cnt < wr_cnt) begin
          r.ev_valid = 1'b1;
          r.kind = store[rd_cnt].kind;
          r.key = store[rd_cnt].key;
          rd_cnt++;
          if (rd_cnt == wr_cnt) begin
            rd_cnt = 0;
            wr_cnt = 0;
          end
        end
      end else begin
        any = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
          down = levels[k];
          case (mode[k])
            KEY_REL_PRESSED, KEY_REL_HELD: begin
              if (down) begin
                mode[k] = (mode[k] == KEY_REL_PRESSED) ? KEY_PRESSED : KEY_HELD;
              end else if (reached(now, since_ms[k], release_ms)) begin
                mode[k] = KEY_IDLE;
                push_event(bphrd_pkg::KIND_RELEASE, k[bphrd_pkg::KEY_W-1:0]);
                any = 1'b1;
              end
            end
            KEY_PENDING: begin
              if (!down) begin
                mode[k] = KEY_IDLE;
              end else if (reached(now, since_ms[k], press_ms)) begin
                mode[k] = KEY_PRESSED;
                push_event(bphrd_pkg::KIND_PRESS, k[bphrd_pkg::KEY_W-1:0]);
                any = 1'b1;
              end
            end
            KEY_PRESSED: begin
              if (!down) begin
                since_ms[k] = now;
                mode[k] = KEY_REL_PRESSED;
              end else if (reached(now, since_ms[k], hold_ms)) begin
                mode[k] = KEY_HELD;
                push_event(bphrd_pkg::KIND_HOLD, k[bphrd_pkg::KEY_W-1:0]);
                any = 1'b1;
              end
            end
            KEY_HELD: begin
              if (!down) begin
                since_ms[k] = now;
                mode[k] = KEY_REL_HELD;
              end
            end
            default: begin
              mode[k] = KEY_IDLE;
              if (down) begin
                since_ms[k] = now;
                mode[k] = KEY_PENDING;
              end
            end
          endcase
        end
        r.notify = any;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic ev_valid, logic [bphrd_pkg::KIND_W-1:0] kind,
                               logic [bphrd_pkg::KEY_W-1:0] key, logic notify_i);
      result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transfer: valid=%0b kind=%0d key=%0d notify=%0b",
                   ev_valid, kind, key, notify_i);
        end
      end else begin
        want = expected_results.pop_front();
        if (ev_valid === 1'b1) events_read++;
        if (notify_i === 1'b1) notify_ticks++;
        if (ev_valid !== want.ev_valid || kind !== want.kind || key !== want.key ||
            notify_i !== want.notify) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected valid=%0b kind=%0d key=%0d notify=%0b, got %0b %0d %0d %0b",
                     want.ev_valid, want.kind, want.key, want.notify,
                     ev_valid, kind, key, notify_i);
          end
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [bphrd_pkg::ADDR_W-1:0]   cfg_addr = '0;
  logic [bphrd_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           op = bphrd_pkg::OP_SAMPLE;
  logic [bphrd_pkg::LEVEL_W-1:0]  key_levels = '0;
  logic [bphrd_pkg::TIME_W-1:0]   time_now = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           event_valid;
  logic [bphrd_pkg::KIND_W-1:0]   event_kind;
  logic [bphrd_pkg::KEY_W-1:0]    event_key;
  logic                           notify;

  detector_scoreboard sb;
  logic [bphrd_pkg::TIME_W-1:0]   clock_ms;
  bit                             gaps_on = 1'b1;
  bit                             stall_on = 1'b1;
  int unsigned                    items_sent = 0;
  int unsigned                    settings_used = 1;
  int unsigned                    cycle_count = 0;

  button_press_hold_release_detector_core #(
    .KEYS(NUM_KEYS),
    .EVENT_DEPTH(STORE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .key_levels(key_levels),
    .time_now(time_now),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_valid(event_valid),
    .event_kind(event_kind),
    .event_key(event_key),
    .notify(notify)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic op_i, input logic [bphrd_pkg::LEVEL_W-1:0] levels,
                           input logic [bphrd_pkg::TIME_W-1:0] now);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op = op_i;
    key_levels = levels;
    time_now = now;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(op_i, levels, now);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bphrd_pkg::ADDR_W-1:0] idx,
                           input logic [bphrd_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_timing(input logic [bphrd_pkg::CFG_W-1:0] p,
                            input logic [bphrd_pkg::CFG_W-1:0] r,
                            input logic [bphrd_pkg::CFG_W-1:0] h);
    write_reg(bphrd_pkg::REG_PRESS_MS, p);
    write_reg(bphrd_pkg::REG_RELEASE_MS, r);
    write_reg(bphrd_pkg::REG_HOLD_MS, h);
    settings_used++;
  endtask

  task automatic sample_tick(input logic down, input int unsigned step_max);
    logic [bphrd_pkg::LEVEL_W-2:0] other_keys;
    other_keys = (bphrd_pkg::LEVEL_W-1)'($urandom);
    clock_ms += $urandom_range(0, step_max);
    send_item(bphrd_pkg::OP_SAMPLE, {other_keys, down}, clock_ms);
  endtask

  task automatic maybe_read(input int unsigned read_pct);
    logic [bphrd_pkg::LEVEL_W-1:0] junk_levels;
    junk_levels = bphrd_pkg::LEVEL_W'($urandom);
    if ($urandom_range(0, 99) < read_pct) send_item(bphrd_pkg::OP_READ, junk_levels, $urandom);
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned step_max);
    int unsigned first;
    int unsigned n_down;
    int unsigned n_up;
    int unsigned read_pct;
    bit paused;
    logic [bphrd_pkg::LEVEL_W-1:0] noise_levels;
    logic noise_op;
    first = items_sent;
    paused = 1'b0;
    clock_ms = $urandom;
    while (items_sent - first < n_items) begin
      if (!paused && items_sent - first >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
      gaps_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          noise_levels = bphrd_pkg::LEVEL_W'($urandom);
          noise_op = 1'($urandom);
          clock_ms = $urandom;
          send_item(noise_op, noise_levels, clock_ms);
        end
      end else begin
        n_down = $urandom_range(1, 40);
        n_up = $urandom_range(1, 12);
        read_pct = $urandom_range(0, 40);
        for (int i = 0; i < n_down; i++) begin
          maybe_read(read_pct);
          sample_tick($urandom_range(0, 19) != 0, step_max);
        end
        for (int i = 0; i < n_up; i++) begin
          maybe_read(read_pct);
          sample_tick($urandom_range(0, 11) == 0, step_max);
        end
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      stall = stall_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(event_valid, event_kind, event_key, notify);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed sequence at the reset timing: short press, store overflow, bounce, wrap.
    send_item(bphrd_pkg::OP_READ, 8'h00, 32'd1000);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'd1000);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h00, 32'd1010);
    send_item(bphrd_pkg::OP_SAMPLE, 8'hFF, 32'd1020);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'd1069);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'd1070);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'd1519);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'd1520);
    send_item(bphrd_pkg::OP_SAMPLE, 8'hFE, 32'd1530);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'd1540);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h00, 32'd1550);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h00, 32'd1599);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h00, 32'd1600);
    send_item(bphrd_pkg::OP_READ, 8'hFF, 32'hFFFF_FFFF);
    send_item(bphrd_pkg::OP_READ, 8'h00, 32'd0);
    send_item(bphrd_pkg::OP_READ, 8'h00, 32'd0);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'hFFFF_FFE0);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'h0000_0012);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h00, 32'h0000_0020);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'h0000_0030);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'h0000_0213);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h01, 32'h0000_0214);
    send_item(bphrd_pkg::OP_READ, 8'h00, 32'd0);
    send_item(bphrd_pkg::OP_READ, 8'h00, 32'd0);
    send_item(bphrd_pkg::OP_SAMPLE, 8'h00, 32'h0000_0300);
    drain_results();

    run_phase(170, 30);
    drain_results();
    set_timing(16'd0, 16'd0, 16'd0);
    run_phase(170, 3);
    drain_results();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(170, 25000);
    drain_results();
    set_timing(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
               16'($urandom_range(1, 1500)));
    run_phase(170, 40);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d items over %0d timing settings; checked %0d results.",
             items_sent, settings_used, sb.checked);
    $display("Results included %0d stored events read back and %0d sample ticks with notify.",
             sb.events_read, sb.notify_ticks);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/bphrd_pkg.sv
design/bphrd_key_lane.sv
design/bphrd_event_store.sv
design/button_press_hold_release_detector_core.sv
design/bphrd_checker.sv
bench/tb.sv
